// ===== rtl/core/dirty_bitmap_run_extractor_top_macros.svh =====
// Assertion macros for the dirty-bitmap run extractor checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DIRTY_BITMAP_RUN_EXTRACTOR_TOP_MACROS_SVH
`define DIRTY_BITMAP_RUN_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBRE_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBRE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dbre_pkg.sv =====
// Shared types and constants of the dirty-bitmap run extractor.
// No dependencies; used by the top level and its checker.
package dbre_pkg;

  // Width of offsets, lengths and totals on the ports.
  localparam int unsigned FIELD_BITS = 40;
  // Width of one log word on the input port.
  localparam int unsigned LOG_BITS = 64;
  // Widest internal offset counter.
  localparam int unsigned WIDE_BITS = 64;

  localparam int unsigned OUT_TDATA_BITS = 3 * FIELD_BITS;
  localparam int unsigned OUT_TUSER_BITS = 2;

  // Field positions in the result tdata.
  localparam int unsigned OFF_LSB = 0;
  localparam int unsigned LEN_LSB = FIELD_BITS;
  localparam int unsigned TOT_LSB = 2 * FIELD_BITS;

  // Flag positions in the result tuser.
  localparam int unsigned USER_RUN_VALID = 0;
  localparam int unsigned USER_END_OF_SCAN = 1;

  typedef logic [FIELD_BITS-1:0] field_t;

endpackage

// ===== rtl/core/dbre_sat_add.sv =====
// Saturating adder shared by the pending-run, offset and total updates of the run extractor.
// No dependencies.
module dbre_sat_add #(
  parameter int unsigned W = 40
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] sum_o
);

  logic [W:0] full;

  assign full  = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o = full[W] ? '1 : full[W-1:0];

endmodule

// ===== rtl/core/dbre_run_count.sv =====
// Measures the run of equal bits at the top of the remaining log word.
// No dependencies; bits below the remaining count are zero.
module dbre_run_count #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned CNT_W     = 7
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [CNT_W-1:0]     rem_i,
  output logic [CNT_W-1:0]     cnt_o,
  output logic                 lead_o
);

  logic [WORD_BITS-1:0] probe;
  logic [CNT_W-1:0]     lz;
  logic                 lead;

  always_comb begin
    lead  = word_i[WORD_BITS-1];
    probe = lead ? ~word_i : word_i;
    lz    = CNT_W'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (probe[i]) begin
        lz = CNT_W'(WORD_BITS - 1 - i);
      end
    end
    // A run of zeros may reach into the fill bits, so it stops at the word end.
    if (!lead && (lz > rem_i)) begin
      cnt_o = rem_i;
    end else begin
      cnt_o = lz;
    end
    lead_o = lead;
  end

endmodule

// ===== rtl/core/dirty_bitmap_run_extractor_top.sv =====
// A word is accepted in ST_IDLE; each run of equal bits then passes ST_SCAN (run counter) and
// ST_APPLY (shared adder). A ones run after zeros adds ST_CUR, with ST_EMIT before it when the
// zeros close a pending extent, and the last word ends in ST_FINISH with the end result.
// One word at a time; a result waits only when the output register is still held.
// Reset (rst_ni low, asynchronous) clears the scan state, the output valid and base_offset.
module dirty_bitmap_run_extractor_top #(
  parameter int unsigned OFFSET_BITS = 40,
  parameter int unsigned WORD_BITS   = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  dbre_pkg::field_t                      cfg_wdata_i,     // base_offset
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [dbre_pkg::LOG_BITS-1:0]         s_axis_tdata_i,  // log_word
  input  logic                                  s_axis_tlast_i,  // last_word
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // run_offset, run_length, total_dirty from the lowest bit up
  output logic [dbre_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata_o,
  // run_valid, end_of_scan from the lowest bit up
  output logic [dbre_pkg::OUT_TUSER_BITS-1:0]   m_axis_tuser_o,
  output logic                                  m_axis_tlast_o   // last_of_item
);

  localparam int unsigned CNT_W  = $clog2(WORD_BITS + 1);
  localparam int unsigned WIDE_W = dbre_pkg::WIDE_BITS;
  localparam int unsigned FLD_W  = dbre_pkg::FIELD_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_APPLY  = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_CUR    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]             state_q, state_d;
  dbre_pkg::field_t       base_q;
  logic [WORD_BITS-1:0]   w_q, w_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   bit_q, bit_d;
  logic                   last_q, last_d;
  logic                   in_scan_q, in_scan_d;
  logic [OFFSET_BITS-1:0] pz_q, pz_d;
  logic [OFFSET_BITS-1:0] po_q, po_d;
  logic [OFFSET_BITS-1:0] cur_q, cur_d;
  logic [OFFSET_BITS-1:0] tot_q, tot_d;
  logic [OFFSET_BITS-1:0] tmp_q, tmp_d;

  logic                   out_valid_q, out_valid_d;
  dbre_pkg::field_t       out_off_q, out_off_d;
  dbre_pkg::field_t       out_len_q, out_len_d;
  dbre_pkg::field_t       out_tot_q, out_tot_d;
  logic                   out_run_q, out_run_d;
  logic                   out_end_q, out_end_d;
  logic                   out_last_q, out_last_d;

  logic [CNT_W-1:0]       run_cnt;
  logic                   run_bit;
  logic [OFFSET_BITS-1:0] add_a, add_b, add_sum;
  logic [OFFSET_BITS-1:0] cnt_ext;
  logic [WIDE_W-1:0]      cur_wide, po_wide, sum_wide;
  logic                   out_free;
  logic [2:0]             end_state;

  dbre_run_count #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_run_count (
    .word_i (w_q),
    .rem_i  (rem_q),
    .cnt_o  (run_cnt),
    .lead_o (run_bit)
  );

  dbre_sat_add #(
    .W (OFFSET_BITS)
  ) u_sat_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  assign cnt_ext   = OFFSET_BITS'(cnt_q);
  assign cur_wide  = WIDE_W'(cur_q);
  assign po_wide   = WIDE_W'(po_q);
  assign sum_wide  = WIDE_W'(add_sum);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign end_state = last_q ? ST_FINISH : ST_IDLE;

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    last_d      = last_q;
    in_scan_d   = in_scan_q;
    pz_d        = pz_q;
    po_d        = po_q;
    cur_d       = cur_q;
    tot_d       = tot_q;
    tmp_d       = tmp_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_off_d   = out_off_q;
    out_len_d   = out_len_q;
    out_tot_d   = out_tot_q;
    out_run_d   = out_run_q;
    out_end_d   = out_end_q;
    out_last_d  = out_last_q;
    add_a       = tot_q;
    add_b       = po_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          w_d    = s_axis_tdata_i[WORD_BITS-1:0];
          rem_d  = CNT_W'(WORD_BITS);
          last_d = s_axis_tlast_i;
          if (!in_scan_q) begin
            cur_d     = OFFSET_BITS'(base_q);
            in_scan_d = 1'b1;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d   = run_cnt;
        bit_d   = run_bit;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        w_d   = w_q << cnt_q;
        rem_d = rem_q - cnt_q;
        if (!bit_q) begin
          add_a   = pz_q;
          add_b   = cnt_ext;
          pz_d    = add_sum;
          state_d = (rem_q == cnt_q) ? end_state : ST_SCAN;
        end else if (pz_q == '0) begin
          // The ones run continues the pending run.
          add_a   = po_q;
          add_b   = cnt_ext;
          po_d    = add_sum;
          state_d = (rem_q == cnt_q) ? end_state : ST_SCAN;
        end else begin
          add_a   = pz_q;
          add_b   = po_q;
          tmp_d   = add_sum;
          state_d = (po_q != '0) ? ST_EMIT : ST_CUR;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_off_d   = cur_wide[FLD_W-1:0];
          out_len_d   = po_wide[FLD_W-1:0];
          out_tot_d   = '0;
          out_run_d   = 1'b1;
          out_end_d   = 1'b0;
          // The word is already shifted past the new run; any one left closes another.
          out_last_d  = !last_q && (w_q == '0);
          tot_d       = add_sum;
          state_d     = ST_CUR;
        end
      end
      ST_CUR: begin
        add_a   = cur_q;
        add_b   = tmp_q;
        cur_d   = add_sum;
        pz_d    = '0;
        po_d    = cnt_ext;
        state_d = (rem_q == '0) ? end_state : ST_SCAN;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_run_d   = (po_q != '0);
          out_off_d   = (po_q != '0) ? cur_wide[FLD_W-1:0] : '0;
          out_len_d   = po_wide[FLD_W-1:0];
          out_tot_d   = sum_wide[FLD_W-1:0];
          out_end_d   = 1'b1;
          out_last_d  = 1'b1;
          pz_d        = '0;
          po_d        = '0;
          cur_d       = '0;
          tot_d       = '0;
          in_scan_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      in_scan_q   <= 1'b0;
      pz_q        <= '0;
      po_q        <= '0;
      cur_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_scan_q   <= in_scan_d;
      pz_q        <= pz_d;
      po_q        <= po_d;
      cur_q       <= cur_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    bit_q      <= bit_d;
    last_q     <= last_d;
    tmp_q      <= tmp_d;
    out_off_q  <= out_off_d;
    out_len_q  <= out_len_d;
    out_tot_q  <= out_tot_d;
    out_run_q  <= out_run_d;
    out_end_q  <= out_end_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_tot_q, out_len_q, out_off_q};
  assign m_axis_tuser_o  = {out_end_q, out_run_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/core/dbre_checker.sv =====
// Port-level checker for the dirty-bitmap run extractor, bound to the top level.
// Depends on dbre_pkg and the assertion macro header.
`include "dirty_bitmap_run_extractor_top_macros.svh"

module dbre_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_tvalid_i,
  input logic                                s_tready_i,
  input logic                                m_tvalid_i,
  input logic                                m_tready_i,
  input logic [dbre_pkg::OUT_TDATA_BITS-1:0] m_tdata_i,
  input logic [dbre_pkg::OUT_TUSER_BITS-1:0] m_tuser_i,
  input logic                                m_tlast_i
);

  // A stalled result must not change or vanish.
  `DBRE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i) && $stable(m_tlast_i), "result changed while stalled")

  // Each accepted word occupies the sequencer, which then holds input ready low.
  `DBRE_ASSERT_NEXT(a_one_word, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i, "input ready right after a transfer")

  // A result without an extent is only the bare end result.
  `DBRE_ASSERT_NOW(a_bare_end, clk_i, rst_ni, m_tvalid_i && !m_tuser_i[dbre_pkg::USER_RUN_VALID], m_tuser_i[dbre_pkg::USER_END_OF_SCAN] && (m_tdata_i[dbre_pkg::OFF_LSB +: dbre_pkg::FIELD_BITS] == '0) && (m_tdata_i[dbre_pkg::LEN_LSB +: dbre_pkg::FIELD_BITS] == '0), "bare result is not an end result")

  // The end result closes its word.
  `DBRE_ASSERT_NOW(a_end_last, clk_i, rst_ni, m_tvalid_i && m_tuser_i[dbre_pkg::USER_END_OF_SCAN], m_tlast_i, "end result without last flag")

  // The total is reported only on the end result.
  `DBRE_ASSERT_NOW(a_total_zero, clk_i, rst_ni, m_tvalid_i && !m_tuser_i[dbre_pkg::USER_END_OF_SCAN], m_tdata_i[dbre_pkg::TOT_LSB +: dbre_pkg::FIELD_BITS] == '0, "total on a non-end result")

endmodule

bind dirty_bitmap_run_extractor_top dbre_checker u_dbre_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);
